>>> design/sliding_window_percentile_macros.svh
// assertion macros for the sliding window percentile block
// no dependencies; included by files that carry concurrent assertions
`ifndef SLIDING_WINDOW_PERCENTILE_MACROS_SVH
`define SLIDING_WINDOW_PERCENTILE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SWS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define SWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sws_pkg.sv
// shared constants and types for the sliding window percentile block
// no dependencies; imported by the interfaces and every module except sws_ram
`timescale 1ns / 1ps

package sws_pkg;

   // storage shape
   localparam int WINDOW_DEPTH = 512;
   localparam int SAMPLE_BITS  = 32;

   // fixed field widths of the channels and registers
   localparam int FIELD_BITS   = 32;
   localparam int FILL_BITS    = 10;
   localparam int LENGTH_BITS  = 10;
   localparam int PERCENT_BITS = 7;
   localparam int STAT_COUNT   = 3;

   localparam int IDX_BITS   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(WINDOW_DEPTH + 1);

   // rank = floor(product / 100) by reciprocal multiply
   localparam int PROD_BITS   = IDX_BITS + PERCENT_BITS;
   localparam int RECIP_SHIFT = PROD_BITS + 7;
   localparam int RECIP_BITS  = RECIP_SHIFT - 6;
   localparam int SCALED_BITS = PROD_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);

   // two level rank select: groups of cells, then groups
   localparam int LO_BITS     = (IDX_BITS / 2 > 0) ? IDX_BITS / 2 : 1;
   localparam int HI_BITS     = (IDX_BITS - LO_BITS > 0) ? IDX_BITS - LO_BITS : 1;
   localparam int RANK_BITS   = LO_BITS + HI_BITS;
   localparam int GROUP_SIZE  = 2 ** LO_BITS;
   localparam int GROUP_SLOTS = 2 ** HI_BITS;

   localparam logic [PERCENT_BITS-1:0] PERCENT_MAX = PERCENT_BITS'(100);

   // register file
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd0;
   localparam logic [1:0] REG_FIRST_PERCENT  = 2'd1;
   localparam logic [1:0] REG_SECOND_PERCENT = 2'd2;
   localparam logic [1:0] REG_THIRD_PERCENT  = 2'd3;

   localparam logic [LENGTH_BITS-1:0]  WINDOW_LENGTH_RESET  = LENGTH_BITS'(512);
   localparam logic [PERCENT_BITS-1:0] FIRST_PERCENT_RESET  = PERCENT_BITS'(50);
   localparam logic [PERCENT_BITS-1:0] SECOND_PERCENT_RESET = PERCENT_BITS'(95);
   localparam logic [PERCENT_BITS-1:0] THIRD_PERCENT_RESET  = PERCENT_BITS'(99);

   // broadcast to every cell of the sorted chain
   typedef struct packed {
      logic                   evict;
      logic                   insert;
      logic [SAMPLE_BITS-1:0] key;
   } cell_ctrl_type;

endpackage

>>> design/sws_req_if.sv
// request channel carrying one latency sample per transaction
// depends on sws_pkg
`timescale 1ns / 1ps

interface sws_req_if;
   import sws_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] sample_time;

   modport source (output valid, output sample_time, input ready);
   modport sink (input valid, input sample_time, output ready);
endinterface

>>> design/sws_rsp_if.sv
// response channel carrying the newest sample, fill count and three order statistics
// depends on sws_pkg
`timescale 1ns / 1ps

interface sws_rsp_if;
   import sws_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] newest_sample;
   logic [FIELD_BITS-1:0] first_stat;
   logic [FIELD_BITS-1:0] second_stat;
   logic [FIELD_BITS-1:0] third_stat;
   logic [FILL_BITS-1:0]  fill_count;

   modport source (output valid, output newest_sample, output first_stat,
                   output second_stat, output third_stat, output fill_count,
                   input ready);
   modport sink (input valid, input newest_sample, input first_stat,
                 input second_stat, input third_stat, input fill_count,
                 output ready);
endinterface

>>> design/sws_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;
endmodule

>>> design/sws_cell.sv
// one cell of the sorted chain: holds one sample, shifts left on eviction, right on insertion
// depends on sws_pkg
`timescale 1ns / 1ps

module sws_cell (
   input  logic                            clock,
   input  sws_pkg::cell_ctrl_type          ctrl,
   input  logic                            cell_valid,
   input  logic [sws_pkg::SAMPLE_BITS-1:0] left_value,
   input  logic                            left_cmp,
   input  logic [sws_pkg::SAMPLE_BITS-1:0] right_value,
   output logic [sws_pkg::SAMPLE_BITS-1:0] value,
   output logic                            cmp
);
   import sws_pkg::*;

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [SAMPLE_BITS-1:0] value_in;

   // eviction marks every cell at or above the leaving value, insertion those above the key
   always_comb begin
      if (ctrl.evict) begin
         cmp = cell_valid && (value_ff >= ctrl.key);
      end else begin
         cmp = cell_valid && (value_ff > ctrl.key);
      end
   end

   always_comb begin
      value_in = value_ff;
      if (ctrl.evict) begin
         if (cmp) begin
            value_in = right_value;
         end
      end else if (ctrl.insert) begin
         if (left_cmp) begin
            value_in = left_value;
         end else if (!cell_valid || cmp) begin
            value_in = ctrl.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

>>> design/sws_rank.sv
// rank unit: floor((count-1) * percent / 100), percent saturated at 100, in two registered multiply steps
// depends on sws_pkg
`timescale 1ns / 1ps

module sws_rank (
   input  logic                             clock,
   input  logic [sws_pkg::IDX_BITS-1:0]     count_m1,
   input  logic [sws_pkg::PERCENT_BITS-1:0] percent,
   input  logic                             load_product,
   input  logic                             load_rank,
   output logic [sws_pkg::RANK_BITS-1:0]    rank
);
   import sws_pkg::*;

   logic [PERCENT_BITS-1:0] percent_sat;
   logic [PROD_BITS-1:0]    product_ff;
   logic [SCALED_BITS-1:0]  scaled;
   logic [RANK_BITS-1:0]    rank_ff;

   assign percent_sat = (percent > PERCENT_MAX) ? PERCENT_MAX : percent;
   assign scaled      = SCALED_BITS'(product_ff) * SCALED_BITS'(RECIP);

   always_ff @(posedge clock) begin
      if (load_product) begin
         product_ff <= PROD_BITS'(count_m1) * PROD_BITS'(percent_sat);
      end
      if (load_rank) begin
         rank_ff <= scaled[RECIP_SHIFT +: RANK_BITS];
      end
   end

   assign rank = rank_ff;
endmodule

>>> design/sliding_window_percentile.sv
// flow: a request is taken in idle, then check, one evict and check pass per sample to drop,
// insert, multiply, divide, select and gather; the response register loads from gather, which waits
// while a response is held; no new request is taken until the block is back in idle
// reset: synchronous, clears fill count, ring pointer, handshake state and loads the register
// defaults (length 512, percents 50, 95, 99); sample storage is not cleared
`timescale 1ns / 1ps
`include "sliding_window_percentile_macros.svh"

module sliding_window_percentile (
   input  logic                               clock,
   input  logic                               reset,
   sws_req_if.sink                            req_if,
   sws_rsp_if.source                          rsp_if,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sws_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [sws_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [sws_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import sws_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CHECK  = 8'b0000_0010,
      ST_EVICT  = 8'b0000_0100,
      ST_INSERT = 8'b0000_1000,
      ST_MUL    = 8'b0001_0000,
      ST_DIV    = 8'b0010_0000,
      ST_SELECT = 8'b0100_0000,
      ST_GATHER = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [LENGTH_BITS-1:0]  window_length_ff;
   logic [PERCENT_BITS-1:0] percent_ff [STAT_COUNT];
   logic                    csr_write;
   logic [1:0]              csr_index;

   // window bookkeeping
   logic [IDX_BITS-1:0]    oldest_ff, oldest_in;
   logic [COUNT_BITS-1:0]  held_count_ff, held_count_in;
   logic [COUNT_BITS-1:0]  eff_len;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [IDX_BITS:0]      slot_sum;
   logic [IDX_BITS-1:0]    write_slot;
   logic [SAMPLE_BITS-1:0] gone_value;

   // sorted chain
   cell_ctrl_type          cell_ctrl;
   logic [SAMPLE_BITS-1:0] cell_value [WINDOW_DEPTH];
   logic                   cell_cmp   [WINDOW_DEPTH];
   logic                   cell_valid [WINDOW_DEPTH];

   // rank select
   logic [RANK_BITS-1:0]   rank [STAT_COUNT];
   logic [SAMPLE_BITS-1:0] leaf [GROUP_SLOTS][GROUP_SIZE];
   logic [SAMPLE_BITS-1:0] group_sel_ff [STAT_COUNT][GROUP_SLOTS];

   // response register
   logic                  rsp_valid_ff;
   logic [FIELD_BITS-1:0] rsp_newest_ff;
   logic [FIELD_BITS-1:0] rsp_stat_ff [STAT_COUNT];
   logic [FILL_BITS-1:0]  rsp_fill_ff;
   logic                  rsp_load;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
         percent_ff[0]    <= FIRST_PERCENT_RESET;
         percent_ff[1]    <= SECOND_PERCENT_RESET;
         percent_ff[2]    <= THIRD_PERCENT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WINDOW_LENGTH:  window_length_ff <= csr_pwdata[LENGTH_BITS-1:0];
            REG_FIRST_PERCENT:  percent_ff[0]    <= csr_pwdata[PERCENT_BITS-1:0];
            REG_SECOND_PERCENT: percent_ff[1]    <= csr_pwdata[PERCENT_BITS-1:0];
            REG_THIRD_PERCENT:  percent_ff[2]    <= csr_pwdata[PERCENT_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_WINDOW_LENGTH:  csr_prdata = CSR_DATA_BITS'(window_length_ff);
         REG_FIRST_PERCENT:  csr_prdata = CSR_DATA_BITS'(percent_ff[0]);
         REG_SECOND_PERCENT: csr_prdata = CSR_DATA_BITS'(percent_ff[1]);
         REG_THIRD_PERCENT:  csr_prdata = CSR_DATA_BITS'(percent_ff[2]);
      endcase
   end

   // zero length keeps one sample, oversize saturates to the depth
   always_comb begin
      if (window_length_ff == '0) begin
         eff_len = COUNT_BITS'(1);
      end else if (32'(window_length_ff) > WINDOW_DEPTH) begin
         eff_len = COUNT_BITS'(WINDOW_DEPTH);
      end else begin
         eff_len = COUNT_BITS'(window_length_ff);
      end
   end

   // ---------------- control ----------------
   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_load     = (state_ff == ST_GATHER) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (held_count_ff >= eff_len) begin
               state_in = ST_EVICT;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_EVICT:  state_in = ST_CHECK;
         ST_INSERT: state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    state_in = ST_SELECT;
         ST_SELECT: state_in = ST_GATHER;
         ST_GATHER: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ring slot of the new sample, oldest plus fill, wrapped at the depth
   assign slot_sum   = (IDX_BITS + 1)'(oldest_ff) + (IDX_BITS + 1)'(held_count_ff);
   assign write_slot = (slot_sum >= (IDX_BITS + 1)'(WINDOW_DEPTH))
                       ? IDX_BITS'(slot_sum - (IDX_BITS + 1)'(WINDOW_DEPTH))
                       : IDX_BITS'(slot_sum);

   always_comb begin
      oldest_in     = oldest_ff;
      held_count_in = held_count_ff;
      if (state_ff == ST_EVICT) begin
         held_count_in = held_count_ff - COUNT_BITS'(1);
         if (oldest_ff == IDX_BITS'(WINDOW_DEPTH - 1)) begin
            oldest_in = '0;
         end else begin
            oldest_in = oldest_ff + IDX_BITS'(1);
         end
      end else if (state_ff == ST_INSERT) begin
         held_count_in = held_count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         oldest_ff     <= '0;
         held_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         sample_ff <= SAMPLE_BITS'(req_if.sample_time);
      end
   end

   // arrival order; read address follows the oldest pointer so data is ready in the evict step
   sws_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_arrival_ring (
      .clock         (clock),
      .write_enable  (state_ff == ST_INSERT),
      .write_address (write_slot),
      .write_data    (sample_ff),
      .read_address  (oldest_ff),
      .read_data     (gone_value)
   );

   // ---------------- sorted cell chain ----------------
   always_comb begin
      cell_ctrl.evict  = (state_ff == ST_EVICT);
      cell_ctrl.insert = (state_ff == ST_INSERT);
      cell_ctrl.key    = (state_ff == ST_EVICT) ? gone_value : sample_ff;
   end

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] left_value;
      logic                   left_cmp;
      logic [SAMPLE_BITS-1:0] right_value;

      assign cell_valid[i] = (COUNT_BITS'(i) < held_count_ff);

      if (i == 0) begin : g_first
         assign left_value = '0;
         assign left_cmp   = 1'b0;
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
         assign left_cmp   = cell_cmp[i-1];
      end

      if (i == WINDOW_DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
      end

      sws_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .cell_valid  (cell_valid[i]),
         .left_value  (left_value),
         .left_cmp    (left_cmp),
         .right_value (right_value),
         .value       (cell_value[i]),
         .cmp         (cell_cmp[i])
      );
   end

   // ---------------- ranks and selection ----------------
   for (genvar k = 0; k < STAT_COUNT; k++) begin : g_rank
      sws_rank u_rank (
         .clock        (clock),
         .count_m1     (IDX_BITS'(held_count_ff - COUNT_BITS'(1))),
         .percent      (percent_ff[k]),
         .load_product (state_ff == ST_MUL),
         .load_rank    (state_ff == ST_DIV),
         .rank         (rank[k])
      );
   end

   for (genvar g = 0; g < GROUP_SLOTS; g++) begin : g_group
      for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_leaf
         if (g * GROUP_SIZE + j < WINDOW_DEPTH) begin : g_used
            assign leaf[g][j] = cell_value[g * GROUP_SIZE + j];
         end else begin : g_unused
            assign leaf[g][j] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SELECT) begin
         for (int k = 0; k < STAT_COUNT; k++) begin
            for (int g = 0; g < GROUP_SLOTS; g++) begin
               group_sel_ff[k][g] <= leaf[g][rank[k][LO_BITS-1:0]];
            end
         end
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_newest_ff <= FIELD_BITS'(sample_ff);
         rsp_fill_ff   <= FILL_BITS'(held_count_ff);
         for (int k = 0; k < STAT_COUNT; k++) begin
            rsp_stat_ff[k] <= FIELD_BITS'(group_sel_ff[k][rank[k][RANK_BITS-1:LO_BITS]]);
         end
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.newest_sample = rsp_newest_ff;
   assign rsp_if.first_stat    = rsp_stat_ff[0];
   assign rsp_if.second_stat   = rsp_stat_ff[1];
   assign rsp_if.third_stat    = rsp_stat_ff[2];
   assign rsp_if.fill_count    = rsp_fill_ff;

   // ---------------- assertions ----------------
   `SWS_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, held_count_ff <= COUNT_BITS'(WINDOW_DEPTH), "fill count above depth")
   `SWS_ASSERT_NEXT(a_evict_step, clock, reset, state_ff == ST_EVICT, (state_ff == ST_CHECK) && (held_count_ff == $past(held_count_ff) - COUNT_BITS'(1)), "eviction did not drop one sample")
   `SWS_ASSERT_NEXT(a_insert_fits, clock, reset, state_ff == ST_INSERT, (held_count_ff != '0) && (held_count_ff <= eff_len), "insertion left fill outside window")
   `SWS_ASSERT_IMPLIES(a_rsp_fill, clock, reset, rsp_valid_ff, rsp_fill_ff != '0, "response with empty window")

endmodule

>>> tb/sv/percentile_checker.sv
// watches the sample, report and register channels of the percentile filter
// and predicts each report; depends on sws_pkg
`timescale 1ns / 1ps

module percentile_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [sws_pkg::FIELD_BITS-1:0]    req_sample_time,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [sws_pkg::FIELD_BITS-1:0]    rsp_newest_sample,
   input  logic [sws_pkg::FIELD_BITS-1:0]    rsp_first_stat,
   input  logic [sws_pkg::FIELD_BITS-1:0]    rsp_second_stat,
   input  logic [sws_pkg::FIELD_BITS-1:0]    rsp_third_stat,
   input  logic [sws_pkg::FILL_BITS-1:0]     rsp_fill_count,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic                              csr_pready,
   input  logic [sws_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sws_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output int                                fail_count,
   output int                                pending_count,
   output int                                report_count
);
   import sws_pkg::*;

   localparam int unsigned REPORT_SLOTS = 16;

   typedef struct packed {
      logic [FIELD_BITS-1:0] newest;
      logic [FIELD_BITS-1:0] first;
      logic [FIELD_BITS-1:0] second;
      logic [FIELD_BITS-1:0] third;
      logic [FILL_BITS-1:0]  fill;
   } window_report_type;

   // predicted reports in order, a small ring with free-running pointers
   window_report_type       expected_reports [REPORT_SLOTS];
   int unsigned             report_wr;
   int unsigned             report_rd;

   // own copy of the window: arrival order and ascending order
   logic [SAMPLE_BITS-1:0]  ring_store   [WINDOW_DEPTH];
   logic [SAMPLE_BITS-1:0]  sorted_store [WINDOW_DEPTH];
   int unsigned             head_idx;
   int unsigned             held;

   logic [LENGTH_BITS-1:0]  length_reg;
   logic [PERCENT_BITS-1:0] first_pct;
   logic [PERCENT_BITS-1:0] second_pct;
   logic [PERCENT_BITS-1:0] third_pct;

   int                      shown;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      report_count  = 0;
      shown         = 0;
      head_idx      = 0;
      held          = 0;
      report_wr     = 0;
      report_rd     = 0;
   end

   function automatic int unsigned active_length();
      int unsigned len;
      len = length_reg;
      if (len == 0) len = 1;
      if (len > WINDOW_DEPTH) len = WINDOW_DEPTH;
      return len;
   endfunction

   function automatic void drop_oldest();
      logic [SAMPLE_BITS-1:0] gone;
      int unsigned            pos;
      int unsigned            i;
      gone = ring_store[head_idx];
      pos  = 0;
      while (pos < held && sorted_store[pos] != gone) pos++;
      if (pos == held) pos = 0;
      for (i = pos; i + 1 < held; i++) sorted_store[i] = sorted_store[i + 1];
      head_idx = (head_idx + 1) % WINDOW_DEPTH;
      held--;
   endfunction

   function automatic void add_sample(input logic [SAMPLE_BITS-1:0] value);
      int unsigned i;
      ring_store[(head_idx + held) % WINDOW_DEPTH] = value;
      i = held;
      while (i > 0 && sorted_store[i - 1] > value) begin
         sorted_store[i] = sorted_store[i - 1];
         i--;
      end
      sorted_store[i] = value;
      held++;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] rank_value(input logic [PERCENT_BITS-1:0] pct);
      int unsigned p;
      int unsigned rank;
      p = (pct > PERCENT_MAX) ? 100 : pct;
      rank = ((held - 1) * p) / 100;
      return sorted_store[rank];
   endfunction

   function automatic window_report_type predict_report(input logic [FIELD_BITS-1:0] value);
      window_report_type r;
      // a shrunk window may shed several samples before the insertion
      while (held >= active_length()) drop_oldest();
      add_sample(SAMPLE_BITS'(value));
      r.newest = value;
      r.first  = FIELD_BITS'(rank_value(first_pct));
      r.second = FIELD_BITS'(rank_value(second_pct));
      r.third  = FIELD_BITS'(rank_value(third_pct));
      r.fill   = FILL_BITS'(held);
      return r;
   endfunction

   always @(posedge clock) begin
      window_report_type got;
      window_report_type want;
      if (reset) begin
         head_idx   = 0;
         held       = 0;
         length_reg = WINDOW_LENGTH_RESET;
         first_pct  = FIRST_PERCENT_RESET;
         second_pct = SECOND_PERCENT_RESET;
         third_pct  = THIRD_PERCENT_RESET;
         report_wr  = 0;
         report_rd  = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_BITS-1:2])
               REG_WINDOW_LENGTH:  length_reg = csr_pwdata[LENGTH_BITS-1:0];
               REG_FIRST_PERCENT:  first_pct  = csr_pwdata[PERCENT_BITS-1:0];
               REG_SECOND_PERCENT: second_pct = csr_pwdata[PERCENT_BITS-1:0];
               REG_THIRD_PERCENT:  third_pct  = csr_pwdata[PERCENT_BITS-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            if (report_wr - report_rd >= REPORT_SLOTS) begin
               fail_count++;
               if (shown < 10) begin
                  shown++;
                  $display("too many samples outstanding without a report");
               end
            end else begin
               expected_reports[report_wr % REPORT_SLOTS] = predict_report(req_sample_time);
               report_wr++;
            end
         end

         if (rsp_valid && rsp_ready) begin
            got.newest = rsp_newest_sample;
            got.first  = rsp_first_stat;
            got.second = rsp_second_stat;
            got.third  = rsp_third_stat;
            got.fill   = rsp_fill_count;
            report_count++;
            if (report_wr == report_rd) begin
               fail_count++;
               if (shown < 10) begin
                  shown++;
                  $display("report %0d arrived with no sample outstanding: newest=%h fill=%0d",
                           report_count, got.newest, got.fill);
               end
            end else begin
               want = expected_reports[report_rd % REPORT_SLOTS];
               report_rd++;
               if (got.newest !== want.newest || got.first !== want.first ||
                   got.second !== want.second || got.third !== want.third ||
                   got.fill !== want.fill) begin
                  fail_count++;
                  if (shown < 10) begin
                     shown++;
                     $display("report %0d mismatch: expected newest=%h stats=%h %h %h fill=%0d",
                              report_count, want.newest, want.first, want.second, want.third,
                              want.fill);
                     $display("   actual newest=%h stats=%h %h %h fill=%0d",
                              got.newest, got.first, got.second, got.third, got.fill);
                  end
               end
            end
         end
      end
      pending_count = int'(report_wr - report_rd);
   end

endmodule

>>> tb/sv/tb_top.sv
// stimulus and verdict for the sliding window percentile filter
// depends on sws_pkg, the two channel interfaces, the block and percentile_checker
`timescale 1ns / 1ps

module tb_top;
   import sws_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int TAIL_CYCLES  = 64;
   localparam int RANDOM_ITEMS = 1900;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int                       fail_count;
   int                       pending_count;
   int                       report_count;
   int unsigned              cycle_count;
   int unsigned              samples_sent;
   int unsigned              settings_used;
   bit                       send_calm;
   bit                       take_calm;

   sws_req_if req_ch ();
   sws_rsp_if rsp_ch ();

   sliding_window_percentile dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   percentile_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_sample_time   (req_ch.sample_time),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_newest_sample (rsp_ch.newest_sample),
      .rsp_first_stat    (rsp_ch.first_stat),
      .rsp_second_stat   (rsp_ch.second_stat),
      .rsp_third_stat    (rsp_ch.third_stat),
      .rsp_fill_count    (rsp_ch.fill_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .report_count      (report_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL sliding_window_percentile");
         $finish;
      end
   end

   // report side: random stall before each transaction, with calm stretches
   initial begin
      int unsigned stall;
      rsp_ch.ready = 1'b0;
      take_calm    = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
         stall = take_calm ? 0 : $urandom_range(0, 16);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   task automatic send_sample(input logic [FIELD_BITS-1:0] value);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.sample_time <= value;
      do @(posedge clock); while (!req_ch.ready);
      samples_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (pending_count == 0);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // registers only change once every report is back
   task automatic apply_setting(input logic [LENGTH_BITS-1:0] len,
                                input logic [PERCENT_BITS-1:0] p1,
                                input logic [PERCENT_BITS-1:0] p2,
                                input logic [PERCENT_BITS-1:0] p3);
      hold_until_drained();
      csr_write(REG_WINDOW_LENGTH, CSR_DATA_BITS'(len));
      csr_write(REG_FIRST_PERCENT, CSR_DATA_BITS'(p1));
      csr_write(REG_SECOND_PERCENT, CSR_DATA_BITS'(p2));
      csr_write(REG_THIRD_PERCENT, CSR_DATA_BITS'(p3));
      settings_used++;
   endtask

   function automatic logic [PERCENT_BITS-1:0] pick_percent();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return PERCENT_MAX;
         2:       return PERCENT_BITS'($urandom_range(101, 127));
         default: return PERCENT_BITS'($urandom_range(0, 100));
      endcase
   endfunction

   function automatic logic [LENGTH_BITS-1:0] pick_length();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return LENGTH_BITS'(1);
         2:       return LENGTH_BITS'(WINDOW_DEPTH);
         3:       return LENGTH_BITS'($urandom_range(WINDOW_DEPTH + 1, 1023));
         default: return LENGTH_BITS'($urandom_range(2, 48));
      endcase
   endfunction

   // narrow ranges give plenty of equal samples
   function automatic logic [FIELD_BITS-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return FIELD_BITS'($urandom_range(0, 15));
         4:       return $urandom & 32'hFFFF_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int unsigned            phase;
      int unsigned            items;
      int unsigned            sent_random;
      logic [LENGTH_BITS-1:0] len;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.sample_time = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      send_calm          = 1'b0;
      samples_sent       = 0;
      settings_used      = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: field extremes and repeated values
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h0000_0001);
      send_sample(32'hFFFF_FFFE);
      send_sample(32'h0000_0400);
      send_sample(32'h0000_0400);
      send_sample(32'h0000_0400);
      send_sample(32'hAAAA_AAAA);
      send_sample(32'h5555_5555);

      // shrink below the fill, percents at zero, full and above full
      apply_setting(LENGTH_BITS'(3), '0, PERCENT_MAX, PERCENT_BITS'(127));
      send_sample(32'h0000_1234);
      send_sample(32'h0000_0400);

      // zero length behaves as a single sample window
      apply_setting('0, PERCENT_BITS'(50), PERCENT_BITS'(1), PERCENT_BITS'(99));
      send_sample(32'hDEAD_BEEF);
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFF);

      // length beyond the depth saturates
      apply_setting(LENGTH_BITS'(1023), PERCENT_MAX, '0, PERCENT_BITS'(50));
      send_sample(32'h0001_0000);
      send_sample(32'h0000_0010);
      send_sample(32'h0100_0000);

      apply_setting(LENGTH_BITS'(2), '0, PERCENT_BITS'(50), PERCENT_MAX);
      send_sample(32'h0000_0400);
      send_sample(32'h0000_0400);
      send_sample(32'h0000_03FF);

      phase       = 0;
      sent_random = 0;
      while (sent_random < RANDOM_ITEMS) begin
         case (phase)
            0:       begin len = LENGTH_BITS'(WINDOW_DEPTH); items = 600; end
            1:       begin len = LENGTH_BITS'(1);            items = 60;  end
            2:       begin len = LENGTH_BITS'(1023);         items = 560; end
            3:       begin len = '0;                         items = 40;  end
            default: begin len = pick_length(); items = $urandom_range(60, 120); end
         endcase
         apply_setting(len, pick_percent(), pick_percent(), pick_percent());
         repeat (items) begin
            if ($urandom_range(0, 249) == 0) hold_until_drained();
            send_sample(draw_sample());
            sent_random++;
         end
         phase++;
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d samples sent under %0d register settings, %0d reports checked",
               samples_sent, settings_used, report_count);
      $display("covered zero, saturated and shrinking windows and percents up to 127");
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS sliding_window_percentile");
      end else begin
         $display("FAIL sliding_window_percentile");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/sws_pkg.sv
design/sws_req_if.sv
design/sws_rsp_if.sv
design/sws_ram.sv
design/sws_cell.sv
design/sws_rank.sv
design/sliding_window_percentile.sv
tb/sv/percentile_checker.sv
tb/sv/tb_top.sv
